/* rtl/core/ihx_pkg.sv */
// ihx_pkg: shared types, record type codes and verdict codes for the
// intel hex record checker. No dependencies.
package ihx_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned POS_W  = 9;

    // record type field values
    localparam logic [7:0] REC_DATA      = 8'h00;
    localparam logic [7:0] REC_EOF       = 8'h01;
    localparam logic [7:0] REC_EXT_SEG   = 8'h02;
    localparam logic [7:0] REC_START_SEG = 8'h03;
    localparam logic [7:0] REC_EXT_LIN   = 8'h04;
    localparam logic [7:0] REC_START_LIN = 8'h05;

    // verdict codes
    localparam logic [3:0] VERDICT_TEXT     = 4'd0;
    localparam logic [3:0] VERDICT_IMAGE    = 4'd1;
    localparam logic [3:0] VERDICT_EOF      = 4'd2;
    localparam logic [3:0] VERDICT_BASE     = 4'd3;
    localparam logic [3:0] VERDICT_START    = 4'd4;
    localparam logic [3:0] VERDICT_CHECKSUM = 4'd5;
    localparam logic [3:0] VERDICT_LENGTH   = 4'd6;
    localparam logic [3:0] VERDICT_OUTSIDE  = 4'd7;
    localparam logic [3:0] VERDICT_TYPE     = 4'd8;

    // configuration register indexes
    localparam logic [1:0] CFG_PROG_BASE = 2'd0;
    localparam logic [1:0] CFG_PROG_LEN  = 2'd1;
    localparam logic [1:0] CFG_IMG_BASE  = 2'd2;
    localparam logic [1:0] CFG_IMG_LEN   = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] prog_base;
        logic [ADDR_W:0]   prog_top;
        logic [ADDR_W-1:0] img_base;
        logic [ADDR_W:0]   img_top;
        logic              img_en;
    } t_win;

    typedef struct packed {
        logic [7:0]        sum;
        logic [7:0]        kind;
        logic [7:0]        count;
        logic [15:0]       offset;
        logic [7:0]        first;
        logic [7:0]        second;
        logic [ADDR_W:0]   lo;
        logic [ADDR_W:0]   hi;
        logic [ADDR_W-1:0] upper_base;
    } t_rec;

    typedef struct packed {
        logic [3:0]        verdict;
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        byte_count;
        logic [ADDR_W-1:0] base_now;
    } t_res;

endpackage

/* rtl/core/ihex_record_checker.sv */
// ihex_record_checker: top level with configuration registers, input
// register and result register. Depends on ihx_pkg, ihx_parser.
//
// Takes raw intel hex record bytes, one per transfer, and gives one verdict per
// record on its checksum byte (checksum, type, count and address window tests,
// extended segment and linear base tracking). A byte is taken every clock
// unless a stalled consumer holds the result register: it lands in the input
// register, is parsed as it leaves it, and its verdict, if any, lands in the
// result register, which drives o_out_valid. Throughput is one byte per cycle,
// limited only by the result register when the consumer stalls. Config writes
// pass through the config registers and then the r_win window register before
// they reach the comparators.
module ihex_record_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [1:0]                i_cfg_index,
    input  logic [ihx_pkg::ADDR_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [7:0]                i_record_byte,
    input  logic                      i_record_start,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [3:0]                o_verdict,
    output logic [ihx_pkg::ADDR_W-1:0] o_write_address,
    output logic [7:0]                o_byte_count,
    output logic [ihx_pkg::ADDR_W-1:0] o_base_now
);
    import ihx_pkg::*;

    logic [ADDR_W-1:0] r_prog_base;
    logic [ADDR_W-1:0] r_prog_len;
    logic [ADDR_W-1:0] r_img_base;
    logic [ADDR_W-1:0] r_img_len;
    t_win              r_win;

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_start;

    logic              r_out_valid;
    t_res              r_out;

    logic              go;
    logic              res_valid;
    t_res              res;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_base <= '0;
            r_prog_len  <= '0;
            r_img_base  <= '0;
            r_img_len   <= '0;
            r_win       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_PROG_BASE: r_prog_base <= i_cfg_data;
                    CFG_PROG_LEN:  r_prog_len  <= i_cfg_data;
                    CFG_IMG_BASE:  r_img_base  <= i_cfg_data;
                    CFG_IMG_LEN:   r_img_len   <= i_cfg_data;
                    default: ;
                endcase
            end
            r_win.prog_base <= r_prog_base;
            r_win.prog_top  <= {1'b0, r_prog_base} + {1'b0, r_prog_len};
            r_win.img_base  <= r_img_base;
            r_win.img_top   <= {1'b0, r_img_base} + {1'b0, r_img_len};
            r_win.img_en    <= (r_img_len != '0);
        end
    end

    assign go         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || go;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte  <= i_record_byte;
            r_in_start <= i_record_start;
        end
    end

    ihx_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_byte      (r_in_byte),
        .i_start     (r_in_start),
        .i_win       (r_win),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out_valid <= res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_verdict       = r_out.verdict;
    assign o_write_address = r_out.write_address;
    assign o_byte_count    = r_out.byte_count;
    assign o_base_now      = r_out.base_now;

endmodule

/* rtl/core/ihx_judge.sv */
// ihx_judge: verdict logic for one completed record, checksum first,
// then type, count and window tests. Depends on ihx_pkg.
module ihx_judge (
    input  ihx_pkg::t_rec i_rec,
    input  ihx_pkg::t_win i_win,
    output ihx_pkg::t_res o_res
);
    import ihx_pkg::*;

    logic in_prog;
    logic in_img;
    logic hdr_zero;

    assign in_prog  = (i_rec.lo >= {1'b0, i_win.prog_base}) && (i_rec.hi <= i_win.prog_top);
    assign in_img   = i_win.img_en && (i_rec.lo >= {1'b0, i_win.img_base})
                      && (i_rec.hi <= i_win.img_top);
    assign hdr_zero = (i_rec.offset == 16'h0000);

    always_comb begin
        o_res.verdict       = VERDICT_TYPE;
        o_res.write_address = '0;
        o_res.byte_count    = i_rec.count;
        o_res.base_now      = i_rec.upper_base;
        if (i_rec.sum != 8'h00) begin
            o_res.verdict = VERDICT_CHECKSUM;
        end else begin
            case (i_rec.kind)
                REC_DATA: begin
                    o_res.write_address = i_rec.lo[ADDR_W-1:0];
                    if (in_prog) begin
                        o_res.verdict = VERDICT_TEXT;
                    end else if (in_img) begin
                        o_res.verdict = VERDICT_IMAGE;
                    end else begin
                        o_res.verdict = VERDICT_OUTSIDE;
                    end
                end
                REC_EOF: begin
                    if (i_rec.count != 8'd0 || !hdr_zero) begin
                        o_res.verdict = VERDICT_LENGTH;
                    end else begin
                        o_res.verdict = VERDICT_EOF;
                    end
                end
                REC_EXT_SEG, REC_EXT_LIN: begin
                    if (i_rec.count != 8'd2 || !hdr_zero) begin
                        o_res.verdict = VERDICT_LENGTH;
                    end else begin
                        o_res.verdict = VERDICT_BASE;
                        if (i_rec.kind == REC_EXT_SEG) begin
                            o_res.base_now = {12'h000, i_rec.first, i_rec.second, 4'h0};
                        end else begin
                            o_res.base_now = {i_rec.first, i_rec.second, 16'h0000};
                        end
                    end
                end
                REC_START_SEG, REC_START_LIN: begin
                    if (i_rec.count != 8'd4 || !hdr_zero) begin
                        o_res.verdict = VERDICT_LENGTH;
                    end else begin
                        o_res.verdict = VERDICT_START;
                    end
                end
                default: begin
                    o_res.verdict = VERDICT_TYPE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/ihx_parser.sv */
// ihx_parser: per-byte record state (position, header fields, byte sum,
// first data bytes, upper base, record address span). Depends on ihx_pkg, ihx_judge.
module ihx_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [7:0]    i_byte,
    input  logic          i_start,
    input  ihx_pkg::t_win i_win,
    output logic          o_res_valid,
    output ihx_pkg::t_res o_res
);
    import ihx_pkg::*;

    logic [POS_W-1:0]  r_pos;
    logic              r_open;
    logic [7:0]        r_count;
    logic [15:0]       r_offset;
    logic [7:0]        r_kind;
    logic [7:0]        r_sum;
    logic [7:0]        r_first;
    logic [7:0]        r_second;
    logic [ADDR_W-1:0] r_base;
    logic [ADDR_W:0]   r_lo;
    logic [ADDR_W:0]   r_hi;

    logic [7:0]        n_sum;
    logic [POS_W-1:0]  data_end;
    logic              at_check;
    t_rec              rec;

    assign n_sum    = r_sum + i_byte;
    assign data_end = {1'b0, r_count} + POS_W'(4);
    assign at_check = (r_pos >= POS_W'(4)) && !(r_pos < data_end);

    assign rec.sum        = n_sum;
    assign rec.kind       = r_kind;
    assign rec.count      = r_count;
    assign rec.offset     = r_offset;
    assign rec.first      = r_first;
    assign rec.second     = r_second;
    assign rec.lo         = r_lo;
    assign rec.hi         = r_hi;
    assign rec.upper_base = r_base;

    ihx_judge u_judge (
        .i_rec (rec),
        .i_win (i_win),
        .o_res (o_res)
    );

    assign o_res_valid = i_go && !i_start && r_open && at_check;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_open   <= 1'b0;
            r_count  <= '0;
            r_offset <= '0;
            r_kind   <= '0;
            r_sum    <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_base   <= '0;
            r_lo     <= '0;
            r_hi     <= '0;
        end else if (i_go) begin
            if (i_start) begin
                r_open   <= 1'b1;
                r_count  <= i_byte;
                r_sum    <= i_byte;
                r_offset <= '0;
                r_kind   <= '0;
                r_first  <= '0;
                r_second <= '0;
                r_pos    <= POS_W'(1);
            end else if (r_open) begin
                r_sum <= n_sum;
                r_pos <= r_pos + POS_W'(1);
                if (r_pos == POS_W'(1)) begin
                    r_offset[15:8] <= i_byte;
                end else if (r_pos == POS_W'(2)) begin
                    r_offset[7:0] <= i_byte;
                    r_lo <= {1'b0, r_base} + {17'h0_0000, r_offset[15:8], i_byte};
                end else if (r_pos == POS_W'(3)) begin
                    r_kind <= i_byte;
                    r_hi   <= r_lo + {25'h000_0000, r_count};
                end else if (!at_check) begin
                    if (r_pos == POS_W'(4)) begin
                        r_first <= i_byte;
                    end else if (r_pos == POS_W'(5)) begin
                        r_second <= i_byte;
                    end
                end else begin
                    // checksum byte closes the record
                    r_base <= o_res.base_now;
                    r_open <= 1'b0;
                    r_pos  <= '0;
                end
            end
        end
    end

endmodule
